>>> src/sttt_pkg.sv
// Shared types and constants of the software timer task table.
`timescale 1ns / 1ps
`default_nettype none
package sttt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned SLOT_W = 6;

  // Command carried in tuser of the slave side; code 3 is ignored.
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RK_ADD    = 2'd0,
    RK_REMOVE = 2'd1,
    RK_FIRED  = 2'd2,
    RK_DONE   = 2'd3
  } rkind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RM_RD,
    ST_RM_WR,
    ST_TK_RD,
    ST_TK_EV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] timeout;
    logic [TAG_W-1:0]  tag;
    logic              single;
  } entry_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              task_mode;
    logic [TIME_W-1:0] timeout;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] position;
  } item_t;

  typedef struct packed {
    rkind_e            kind;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  fired_tag;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

>>> src/sttt_entry_mem.sv
// Entry memory with one write port and one read port, and registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sttt_entry_mem
  import sttt_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  entry_t             wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/sttt_ctrl.sv
// Command sequencer: add, remove with shift-down, tick scan with compaction.
`timescale 1ns / 1ps
`default_nettype none
module sttt_ctrl
  import sttt_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 32,
  parameter int unsigned AW        = 5,
  parameter int unsigned CW        = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  item_t              in_item_i,
  output logic               in_ready_o,
  input  wire logic          out_free_i,
  output logic               push_o,
  output res_t               res_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output entry_t             mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  entry_t             mem_rdata_i
);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     wr_q, wr_d;
  logic [TIME_W-1:0] now_q, now_d;
  rkind_e            fin_q, fin_d;

  logic              accept;
  logic              full;
  logic              rm_ok;
  logic              more;
  logic              due;
  logic              keep;
  logic              ev_stall;
  logic [CW-1:0]     idx_m1;
  logic [TIME_W-1:0] elapsed;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = cnt_q >= CW'(MAX_TASKS);
  assign rm_ok    = {1'b0, in_item_i.position} < (SLOT_W + 1)'(cnt_q);
  assign more     = idx_q < cnt_q;
  assign elapsed  = now_q - mem_rdata_i.start;
  assign due      = elapsed >= mem_rdata_i.timeout;
  assign keep     = !due || !mem_rdata_i.single;
  assign ev_stall = due && !out_free_i;
  assign idx_m1   = idx_q - 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_e'(in_item_i.kind) == KIND_REMOVE && rm_ok) begin
            state_d = ST_RM_RD;
          end else if (kind_e'(in_item_i.kind) == KIND_TICK) begin
            state_d = ST_TK_RD;
          end
        end
      end
      ST_RM_RD:  state_d = more ? ST_RM_WR : ST_FINISH;
      ST_RM_WR:  state_d = ST_RM_RD;
      ST_TK_RD:  state_d = more ? ST_TK_EV : ST_FINISH;
      ST_TK_EV:  state_d = ev_stall ? ST_TK_EV : ST_TK_RD;
      ST_FINISH: state_d = out_free_i ? ST_IDLE : ST_FINISH;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    now_d       = now_q;
    fin_d       = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free_i;
        if (accept) begin
          unique case (kind_e'(in_item_i.kind))
            KIND_ADD: begin
              push_o      = 1'b1;
              res_o.kind  = RK_ADD;
              res_o.last  = 1'b1;
              if (full) begin
                res_o.status = 1'b1;
              end else begin
                res_o.slot          = SLOT_W'(cnt_q);
                mem_we_o            = 1'b1;
                mem_waddr_o         = cnt_q[AW-1:0];
                mem_wdata_o.start   = now_q;
                mem_wdata_o.timeout = in_item_i.timeout;
                mem_wdata_o.tag     = in_item_i.tag;
                mem_wdata_o.single  = in_item_i.task_mode;
                cnt_d               = cnt_q + 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (rm_ok) begin
                idx_d = CW'(in_item_i.position) + 1'b1;
                fin_d = RK_REMOVE;
              end else begin
                push_o       = 1'b1;
                res_o.kind   = RK_REMOVE;
                res_o.status = 1'b1;
                res_o.last   = 1'b1;
              end
            end
            KIND_TICK: begin
              now_d = now_q + 1'b1;
              idx_d = '0;
              wr_d  = '0;
              fin_d = RK_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_RM_RD: begin
        if (more) begin
          mem_re_o = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_RM_WR: begin
        // Move the entry just read one slot down.
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_m1[AW-1:0];
        idx_d       = idx_q + 1'b1;
      end
      ST_TK_RD: begin
        if (more) begin
          mem_re_o = 1'b1;
        end else begin
          cnt_d = wr_q;
        end
      end
      ST_TK_EV: begin
        if (!ev_stall) begin
          if (due) begin
            push_o          = 1'b1;
            res_o.kind      = RK_FIRED;
            res_o.slot      = SLOT_W'(wr_q);
            res_o.fired_tag = mem_rdata_i.tag;
          end
          // Compact surviving entries toward the front; restart due ones.
          if (keep) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = wr_q[AW-1:0];
            if (due) begin
              mem_wdata_o.start = now_q;
            end
            wr_d = wr_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          res_o.kind = fin_q;
          res_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      now_q   <= '0;
      fin_q   <= RK_DONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      now_q   <= now_d;
      fin_q   <= fin_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_TASKS))
    else $error("entry count above table size");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a full output register");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_EV || state_q == ST_TK_RD) |-> wr_q <= idx_q)
    else $error("compaction write pointer passed the read pointer");

  a_tick_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_EV && mem_we_o) |-> wr_q < cnt_q)
    else $error("tick scan writes beyond the table");

endmodule
`default_nettype wire

>>> src/software_timer_task_table_unit.sv
// Top level of the software timer task table: stream ports and output register.
//
//  Channel   Dir  Signals                          Contents
//  s_axis    in   tvalid/tready/tdata[47:0]/tuser  command and task fields
//  m_axis    out  tvalid/tready/tdata[15:0]/tuser  replies, fired tasks, tick done
//                 /tlast
//
// Add and ignored commands are finished in the cycle they are taken. Remove
// reads each entry above the removed position and writes it one slot lower;
// a tick reads every entry and writes back each surviving one toward the
// front. An item is taken only when the previous one is finished. Reset
// clears the entry count and the millisecond counter; the entry memory is not
// cleared. A stalled master side holds the tick scan at the next due entry.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_task_table_unit
  import sttt_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] task_mode, [32:1] timeout, [40:33] tag, [46:41] position, [47] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] status, [6:1] slot, [14:7] fired_tag, [15] zero
  output logic [15:0]      m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  item_t           item;
  res_t            res;
  res_t            res_q;
  logic            push;
  logic            out_free;
  logic            out_valid_q, out_valid_d;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;

  assign item.kind      = s_axis_tuser;
  assign item.task_mode = s_axis_tdata[0];
  assign item.timeout   = s_axis_tdata[32:1];
  assign item.tag       = s_axis_tdata[40:33];
  assign item.position  = s_axis_tdata[46:41];

  sttt_ctrl #(
    .MAX_TASKS(MAX_TASKS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (item),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  sttt_entry_mem #(
    .DEPTH(MAX_TASKS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register frees up in the same cycle its transaction completes.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.fired_tag, res_q.slot, res_q.status};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule
`default_nettype wire
